>>> rtl/pdc_pkg.sv
// Shared types, constants and arithmetic helpers for the Porter-Duff compositor.
`timescale 1ns / 1ps

package pdc_pkg;

   localparam int unsigned FULL_SCALE = 255;
   localparam int unsigned CHAN_W     = 8;
   localparam int unsigned WEIGHT_W   = 2 * CHAN_W;
   localparam int unsigned NUM_LANES  = 3;
   localparam int unsigned DIV_STEPS  = CHAN_W;

   localparam int unsigned STG_WMUL = 0;
   localparam int unsigned STG_WDIV = 1;
   localparam int unsigned STG_PROD = 2;
   localparam int unsigned STG_SUM  = 3;
   localparam int unsigned STG_DIV0 = 4;
   localparam int unsigned STG_OUT  = STG_DIV0 + DIV_STEPS;
   localparam int unsigned NSTAGE   = STG_OUT + 1;

   typedef logic [NSTAGE-1:0] stage_vec_type;

   typedef enum logic [3:0] {
      OP_CLEAR    = 4'd0,
      OP_SRC      = 4'd1,
      OP_DST      = 4'd2,
      OP_OVER     = 4'd3,
      OP_UNDER    = 4'd4,
      OP_IN       = 4'd5,
      OP_HELD_IN  = 4'd6,
      OP_OUT      = 4'd7,
      OP_HELD_OUT = 4'd8,
      OP_ATOP     = 4'd9,
      OP_BELOW    = 4'd10,
      OP_XOR      = 4'd11
   } op_type;

   typedef enum logic [2:0] {
      SEL_ZERO,
      SEL_FULL,
      SEL_SA,
      SEL_DA,
      SEL_ISA,
      SEL_IDA
   } sel_type;

   typedef struct packed {
      logic [CHAN_W-1:0] cs;
      logic [CHAN_W-1:0] cd;
      logic [CHAN_W-1:0] wa;
      logic [CHAN_W-1:0] wb;
      logic [CHAN_W-1:0] alpha;
   } lane_in_type;

   typedef struct packed {
      logic [CHAN_W-1:0] colour;
      logic [CHAN_W-1:0] alpha;
   } lane_out_type;

   function automatic sel_type src_sel(input logic [3:0] code);
      sel_type s;
      case (code)
         OP_SRC, OP_OVER:                      s = SEL_FULL;
         OP_UNDER, OP_OUT, OP_BELOW, OP_XOR:   s = SEL_IDA;
         OP_IN, OP_ATOP:                       s = SEL_DA;
         default:                              s = SEL_ZERO;
      endcase
      return s;
   endfunction

   function automatic sel_type dst_sel(input logic [3:0] code);
      sel_type s;
      case (code)
         OP_DST, OP_UNDER:                          s = SEL_FULL;
         OP_OVER, OP_HELD_OUT, OP_ATOP, OP_XOR:     s = SEL_ISA;
         OP_HELD_IN, OP_BELOW:                      s = SEL_SA;
         default:                                   s = SEL_ZERO;
      endcase
      return s;
   endfunction

   function automatic logic [CHAN_W-1:0] pick_factor(input sel_type sel,
                                                     input logic [CHAN_W-1:0] sa,
                                                     input logic [CHAN_W-1:0] da);
      logic [CHAN_W-1:0] f;
      case (sel)
         SEL_FULL: f = CHAN_W'(FULL_SCALE);
         SEL_SA:   f = sa;
         SEL_DA:   f = da;
         SEL_ISA:  f = CHAN_W'(FULL_SCALE) - sa;
         SEL_IDA:  f = CHAN_W'(FULL_SCALE) - da;
         default:  f = '0;
      endcase
      return f;
   endfunction

   // Floor division by 255: an estimate from x * (1 + 1/256) / 256 is at most one short,
   // so a single compare of the remainder corrects it.
   function automatic logic [CHAN_W-1:0] div255(input logic [WEIGHT_W:0] x);
      logic [WEIGHT_W+1:0] s;
      logic [WEIGHT_W+1:0] r;
      logic [CHAN_W+1:0]   q0;
      logic [CHAN_W+1:0]   q;
      s  = {1'b0, x} + {{(CHAN_W+1){1'b0}}, x[WEIGHT_W:CHAN_W]};
      q0 = s[WEIGHT_W+1:CHAN_W];
      r  = {1'b0, x} - ({q0, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, q0});
      q  = q0 + ((r >= (WEIGHT_W+2)'(FULL_SCALE)) ? (CHAN_W+2)'(1) : (CHAN_W+2)'(0));
      return q[CHAN_W-1:0];
   endfunction

endpackage

>>> rtl/pdc_weight.sv
// Shared front end: operator factors, alpha weights and the new alpha.
`timescale 1ns / 1ps

module pdc_weight (
   input  logic                                   clock,
   input  pdc_pkg::stage_vec_type                 load,
   input  logic [63:0]                            pixel,
   input  logic [3:0]                             op_code,
   output pdc_pkg::lane_in_type [pdc_pkg::NUM_LANES-1:0] lane_in
);

   localparam int unsigned CW = pdc_pkg::CHAN_W;
   localparam int unsigned WW = pdc_pkg::WEIGHT_W;
   localparam int unsigned NL = pdc_pkg::NUM_LANES;

   logic [WW-1:0]          wa_ff, wb_ff;
   logic [WW-1:0]          wa_in, wb_in;
   logic [NL-1:0][CW-1:0]  src_c_ff, dst_c_ff;
   pdc_pkg::lane_in_type [NL-1:0] lane_ff;
   pdc_pkg::lane_in_type [NL-1:0] lane_in_w;
   logic [CW-1:0]          sa, da, fa, fb;
   logic [CW-1:0]          alpha, wa_t, wb_t;

   assign sa = pixel[4*CW-1:3*CW];
   assign da = pixel[8*CW-1:7*CW];

   always_comb begin
      fa    = pdc_pkg::pick_factor(pdc_pkg::src_sel(op_code), sa, da);
      fb    = pdc_pkg::pick_factor(pdc_pkg::dst_sel(op_code), sa, da);
      wa_in = {{CW{1'b0}}, fa} * {{CW{1'b0}}, sa};
      wb_in = {{CW{1'b0}}, fb} * {{CW{1'b0}}, da};
   end

   always_comb begin
      alpha = pdc_pkg::div255({1'b0, wa_ff} + {1'b0, wb_ff});
      wa_t  = pdc_pkg::div255({1'b0, wa_ff});
      wb_t  = pdc_pkg::div255({1'b0, wb_ff});
      for (int i = 0; i < NL; i++) begin
         lane_in_w[i].cs    = src_c_ff[i];
         lane_in_w[i].cd    = dst_c_ff[i];
         lane_in_w[i].wa    = wa_t;
         lane_in_w[i].wb    = wb_t;
         lane_in_w[i].alpha = alpha;
      end
   end

   always_ff @(posedge clock) begin
      if (load[pdc_pkg::STG_WMUL]) begin
         wa_ff <= wa_in;
         wb_ff <= wb_in;
         for (int i = 0; i < NL; i++) begin
            src_c_ff[i] <= pixel[i*CW +: CW];
            dst_c_ff[i] <= pixel[(i+4)*CW +: CW];
         end
      end
      if (load[pdc_pkg::STG_WDIV]) begin
         lane_ff <= lane_in_w;
      end
   end

   assign lane_in = lane_ff;

endmodule

>>> rtl/pdc_lane.sv
// One colour lane: weighted sum and a pipelined restoring divide by the new alpha.
`timescale 1ns / 1ps

module pdc_lane (
   input  logic                   clock,
   input  pdc_pkg::stage_vec_type load,
   input  pdc_pkg::lane_in_type   lane_in,
   output pdc_pkg::lane_out_type  lane_out
);

   localparam int unsigned CW = pdc_pkg::CHAN_W;
   localparam int unsigned WW = pdc_pkg::WEIGHT_W;
   localparam int unsigned DS = pdc_pkg::DIV_STEPS;

   logic [WW-1:0] ps_ff, pd_ff, sum_ff;
   logic [CW-1:0] a2_ff, a3_ff;
   logic [WW-1:0] rem_ff [DS];
   logic [CW-1:0] quo_ff [DS];
   logic [CW-1:0] dvs_ff [DS];

   always_ff @(posedge clock) begin
      if (load[pdc_pkg::STG_PROD]) begin
         ps_ff <= {{CW{1'b0}}, lane_in.cs} * {{CW{1'b0}}, lane_in.wa};
         pd_ff <= {{CW{1'b0}}, lane_in.cd} * {{CW{1'b0}}, lane_in.wb};
         a2_ff <= lane_in.alpha;
      end
      if (load[pdc_pkg::STG_SUM]) begin
         sum_ff <= ps_ff + pd_ff;
         a3_ff  <= a2_ff;
      end
   end

   for (genvar j = 0; j < DS; j++) begin : g_step
      localparam int unsigned B = DS - 1 - j;
      logic [WW-1:0] rem_src, trial, rem_in;
      logic [CW-1:0] quo_src, dvs_src, quo_in;

      if (j == 0) begin : g_first
         assign rem_src = sum_ff;
         assign quo_src = '0;
         assign dvs_src = a3_ff;
      end else begin : g_next
         assign rem_src = rem_ff[j-1];
         assign quo_src = quo_ff[j-1];
         assign dvs_src = dvs_ff[j-1];
      end

      always_comb begin
         trial  = {{CW{1'b0}}, dvs_src} << B;
         rem_in = rem_src;
         quo_in = quo_src;
         if (rem_src >= trial) begin
            rem_in    = rem_src - trial;
            quo_in[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (load[pdc_pkg::STG_DIV0 + j]) begin
            rem_ff[j] <= rem_in;
            quo_ff[j] <= quo_in;
            dvs_ff[j] <= dvs_src;
         end
      end
   end

   assign lane_out.colour = quo_ff[DS-1];
   assign lane_out.alpha  = dvs_ff[DS-1];

endmodule

>>> rtl/pdc_merge.sv
// Merge stage: gathers the colour lanes and the alpha into the registered result beat.
`timescale 1ns / 1ps

module pdc_merge (
   input  logic                                            clock,
   input  pdc_pkg::stage_vec_type                          load,
   input  pdc_pkg::lane_out_type [pdc_pkg::NUM_LANES-1:0]  lane_out,
   output logic [31:0]                                     result
);

   localparam int unsigned CW = pdc_pkg::CHAN_W;
   localparam int unsigned NL = pdc_pkg::NUM_LANES;

   logic [31:0]   result_ff, result_in;
   logic [CW-1:0] alpha;

   assign alpha = lane_out[0].alpha;

   // With no coverage left the colour is defined as black.
   always_comb begin
      result_in = '0;
      for (int i = 0; i < NL; i++) begin
         result_in[i*CW +: CW] = (alpha == '0) ? '0 : lane_out[i].colour;
      end
      result_in[NL*CW +: CW] = alpha;
   end

   always_ff @(posedge clock) begin
      if (load[pdc_pkg::STG_OUT]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> rtl/porter_duff_compositor_core.sv
// Top level of the Porter-Duff RGBA8 compositor.
`timescale 1ns / 1ps

// Composites one non-premultiplied source pixel over or with one destination pixel per beat
// under the Porter-Duff operator held in the operator register (reset value: over). The
// block takes one pixel per clock unless the full pipeline is held by the result side and
// returns results in order; each pixel passes through the factor multiply, the divide by
// 255, the colour products and sum, the eight-stage restoring divider in each of the three
// colour lanes and the output register. Each stage holds its beat only while the stage
// after it is full, so bubbles are squeezed out when the result side stalls.
module porter_duff_compositor_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_red, out_green, out_blue, out_alpha
   output logic [31:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);

   localparam int unsigned NS = pdc_pkg::NSTAGE;
   localparam int unsigned NL = pdc_pkg::NUM_LANES;

   logic [3:0]                     op_ff;
   logic [NS-1:0]                  vld_ff, vld_in;
   pdc_pkg::stage_vec_type         load;
   pdc_pkg::lane_in_type  [NL-1:0] lane_in;
   pdc_pkg::lane_out_type [NL-1:0] lane_out;

   always_comb begin
      load[NS-1] = !vld_ff[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         load[k] = !vld_ff[k] || load[k+1];
      end
      vld_in[0] = load[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NS; k++) begin
         vld_in[k] = load[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff  <= pdc_pkg::OP_OVER;
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         if (csr_wr_en) begin
            op_ff <= csr_wr_data;
         end
      end
   end

   pdc_weight u_weight (
      .clock   (clock),
      .load    (load),
      .pixel   (req_tdata),
      .op_code (op_ff),
      .lane_in (lane_in)
   );

   for (genvar i = 0; i < NL; i++) begin : g_lane
      pdc_lane u_lane (
         .clock    (clock),
         .load     (load),
         .lane_in  (lane_in[i]),
         .lane_out (lane_out[i])
      );
   end

   pdc_merge u_merge (
      .clock    (clock),
      .load     (load),
      .lane_out (lane_out),
      .result   (rsp_tdata)
   );

   assign req_tready = load[0];
   assign rsp_tvalid = vld_ff[NS-1];

   a_zero_alpha_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[31:24] == 8'd0) |-> (rsp_tdata[23:0] == 24'd0))
      else $error("result with zero alpha carries a colour");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> ((&vld_ff) && !rsp_tready))
      else $error("input held off while the pipeline has a free stage");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (op_ff == $past(csr_wr_data)))
      else $error("operator register missed a write");

endmodule
